>>> sv/x86_alu_shift_unit_with_flags_unit_macros.svh
// ----------------------------------------------------------------------------
// x86 ALU/shift unit assertion macros
// Shared assertion forms for the x86 ALU/shift unit checker.
// ----------------------------------------------------------------------------
`ifndef X86_ALU_SHIFT_UNIT_WITH_FLAGS_UNIT_MACROS_SVH
`define X86_ALU_SHIFT_UNIT_WITH_FLAGS_UNIT_MACROS_SVH

// Clocked implication, disabled while in reset.
`define X86ASU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define X86ASU_NEVER(lbl, expr, msg) \
    `X86ASU_ASSERT(lbl, !(expr), msg)

`endif

>>> sv/x86asu_pkg.sv
// ----------------------------------------------------------------------------
// x86asu_pkg
// Operation codes, flag positions and pipeline types of the x86 ALU/shift unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package x86asu_pkg;

    localparam logic [4:0] ACT_ADD  = 5'd0;
    localparam logic [4:0] ACT_OR   = 5'd1;
    localparam logic [4:0] ACT_ADC  = 5'd2;
    localparam logic [4:0] ACT_SBB  = 5'd3;
    localparam logic [4:0] ACT_AND  = 5'd4;
    localparam logic [4:0] ACT_SUB  = 5'd5;
    localparam logic [4:0] ACT_XOR  = 5'd6;
    localparam logic [4:0] ACT_CMP  = 5'd7;
    localparam logic [4:0] ACT_NOT  = 5'd8;
    localparam logic [4:0] ACT_NEG  = 5'd9;
    localparam logic [4:0] ACT_INC  = 5'd10;
    localparam logic [4:0] ACT_DEC  = 5'd11;
    localparam logic [4:0] ACT_ROL  = 5'd12;
    localparam logic [4:0] ACT_ROR  = 5'd13;
    localparam logic [4:0] ACT_RCL  = 5'd14;
    localparam logic [4:0] ACT_RCR  = 5'd15;
    localparam logic [4:0] ACT_SHL  = 5'd16;
    localparam logic [4:0] ACT_SHR  = 5'd17;
    localparam logic [4:0] ACT_SAL  = 5'd18;
    localparam logic [4:0] ACT_SAR  = 5'd19;
    localparam logic [4:0] ACT_SHLD = 5'd20;
    localparam logic [4:0] ACT_SHRD = 5'd21;

    localparam logic [1:0] WC_64 = 2'd3;

    // flag update modes
    localparam logic [1:0] MODE_KEEP = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_ROT  = 2'd2;

    localparam int FL_CF = 0;
    localparam int FL_ZF = 1;
    localparam int FL_SF = 2;
    localparam int FL_OF = 3;
    localparam int FL_AF = 4;

    typedef struct packed {
        logic [4:0]  act;
        logic [1:0]  wcode;
        logic [63:0] x;
        logic [63:0] y;
        logic [5:0]  c;
        logic [5:0]  rc;
        logic [4:0]  fin;
        logic [7:0]  pin;
    } s1_t;

    typedef struct packed {
        logic [63:0] z;
        logic        cf;
        logic        of;
        logic        af;
        logic [1:0]  mode;
        logic [1:0]  wcode;
        logic [4:0]  fin;
        logic [7:0]  pin;
    } s2_t;

    function automatic logic [63:0] width_mask(input logic [1:0] wc);
        logic [63:0] m;
        begin
            unique case (wc)
                2'd0:    m = 64'h0000_0000_0000_00ff;
                2'd1:    m = 64'h0000_0000_0000_ffff;
                2'd2:    m = 64'h0000_0000_ffff_ffff;
                default: m = 64'hffff_ffff_ffff_ffff;
            endcase
            return m;
        end
    endfunction

    function automatic logic [63:0] width_msb(input logic [1:0] wc);
        logic [63:0] s;
        begin
            unique case (wc)
                2'd0:    s = 64'h0000_0000_0000_0080;
                2'd1:    s = 64'h0000_0000_0000_8000;
                2'd2:    s = 64'h0000_0000_8000_0000;
                default: s = 64'h8000_0000_0000_0000;
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/x86_alu_shift_unit_with_flags_unit.sv
// ----------------------------------------------------------------------------
// x86_alu_shift_unit_with_flags_unit
// x86 integer ALU and barrel shifter with arithmetic flags, three-stage pipe.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive action, width_code, operand_a, operand_b,
//   shift_count, flags_in and parity_byte_in with start high. A request is
//   taken at each rising edge with start high and busy low. busy is always
//   low: the unit takes a new request in every cycle.
//   Result channel: done pulses for one cycle with result, flags_out and
//   parity_byte_out. The receiver cannot stall; results are never held.
//   Path: the request is registered in s1_reg, then s2_reg, then the result
//   registers. Throughput: one request per cycle.
//   Stages: 1 masks operands and counts (rcl/rcr count reduced mod 9/17),
//   2 runs the adder pair and the 128-bit funnel shifter,
//   3 forms ZF/SF, merges flags and picks the parity byte.
//   Reset clears the stage valid bits only; data registers hold garbage
//   that never reaches done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module x86_alu_shift_unit_with_flags_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [4:0]  action,
    input  wire logic [1:0]  width_code,
    input  wire logic [63:0] operand_a,
    input  wire logic [63:0] operand_b,
    input  wire logic [7:0]  shift_count,
    input  wire logic [4:0]  flags_in,
    input  wire logic [7:0]  parity_byte_in,
    output logic             done,
    output logic [63:0]      result,
    output logic [4:0]       flags_out,
    output logic [7:0]       parity_byte_out
);
    import x86asu_pkg::*;

    // ---------------- stage 1: operand masking and count reduction
    s1_t  s1_next, s1_reg;
    logic v1_reg;
    logic [63:0] in_mask;
    logic [5:0]  in_c;
    logic [5:0]  in_rc;

    assign busy = 1'b0;

    always_comb
    begin
        in_mask = width_mask(width_code);
        in_c    = (width_code == WC_64) ? shift_count[5:0] : {1'b0, shift_count[4:0]};
        // rcl/rcr rotate through k+1 bits
        priority if (width_code == 2'd0)
        begin
            if (in_c >= 6'd27)      in_rc = in_c - 6'd27;
            else if (in_c >= 6'd18) in_rc = in_c - 6'd18;
            else if (in_c >= 6'd9)  in_rc = in_c - 6'd9;
            else                    in_rc = in_c;
        end
        else if (width_code == 2'd1)
        begin
            in_rc = (in_c >= 6'd17) ? in_c - 6'd17 : in_c;
        end
        else
        begin
            in_rc = in_c;
        end
        s1_next.act   = action;
        s1_next.wcode = width_code;
        s1_next.x     = operand_a & in_mask;
        s1_next.y     = operand_b & in_mask;
        s1_next.c     = in_c;
        s1_next.rc    = in_rc;
        s1_next.fin   = flags_in;
        s1_next.pin   = parity_byte_in;
    end

    // ---------------- stage 2: adders and shifter
    s2_t  s2_next, s2_reg;
    logic v2_reg;

    logic [63:0]  m2, s2m, s2h, x, y, z;
    logic [6:0]   k, c7, rc7;
    logic [7:0]   k2;
    logic         cin, cf, of, af;
    logic [1:0]   mode;
    logic [64:0]  add65, sub65;
    logic [63:0]  az, sz, sx;
    logic [5:0]   r;
    logic [127:0] dbl, vd, tmp;

    always_comb
    begin
        x    = s1_reg.x;
        y    = s1_reg.y;
        m2   = width_mask(s1_reg.wcode);
        s2m  = width_msb(s1_reg.wcode);
        s2h  = s2m >> 1;
        k    = 7'd8 << s1_reg.wcode;
        k2   = {k, 1'b0};
        c7   = {1'b0, s1_reg.c};
        rc7  = {1'b0, s1_reg.rc};
        cin  = s1_reg.fin[FL_CF];

        add65 = {1'b0, x} + {1'b0, y}
              + {64'd0, (s1_reg.act == ACT_ADC) & cin};
        sub65 = {1'b0, x} - {1'b0, y}
              - {64'd0, (s1_reg.act == ACT_SBB) & cin};
        az = add65[63:0] & m2;
        sz = sub65[63:0] & m2;
        sx = ((x & s2m) != 64'd0) ? (x | ~m2) : x;
        r  = s1_reg.c & 6'(k - 7'd1);
        dbl = ({64'd0, x} << k) | {64'd0, x};
        vd  = 128'd0;
        tmp = 128'd0;

        z    = x;
        cf   = 1'b0;
        of   = 1'b0;
        af   = 1'b0;
        mode = MODE_KEEP;

        unique case (s1_reg.act)
            ACT_ADD, ACT_ADC:
            begin
                z    = az;
                cf   = add65[k];
                of   = ((az ^ x) & (az ^ y) & s2m) != 64'd0;
                af   = (x[4] ^ y[4] ^ az[4]);
                mode = MODE_FULL;
            end
            ACT_SUB, ACT_SBB, ACT_CMP:
            begin
                z    = sz;
                cf   = sub65[k];
                of   = ((x ^ y) & (sz ^ x) & s2m) != 64'd0;
                af   = (x[4] ^ y[4] ^ sz[4]);
                mode = MODE_FULL;
            end
            ACT_OR:
            begin
                z    = x | y;
                mode = MODE_FULL;
            end
            ACT_AND:
            begin
                z    = x & y;
                mode = MODE_FULL;
            end
            ACT_XOR:
            begin
                z    = x ^ y;
                mode = MODE_FULL;
            end
            ACT_NOT:
            begin
                z = ~x & m2;
            end
            ACT_NEG:
            begin
                z    = (64'd0 - x) & m2;
                cf   = x != 64'd0;
                of   = x == s2m;
                af   = x[3:0] != 4'd0;
                mode = MODE_FULL;
            end
            ACT_INC:
            begin
                z    = (x + 64'd1) & m2;
                cf   = cin;
                of   = (((x + 64'd1) & m2 ^ x) & ((x + 64'd1) & m2) & s2m) != 64'd0;
                af   = x[3:0] == 4'hf;
                mode = MODE_FULL;
            end
            ACT_DEC:
            begin
                z    = (x - 64'd1) & m2;
                cf   = cin;
                of   = ((((x - 64'd1) & m2) ^ x) & x & s2m) != 64'd0;
                af   = x[3:0] == 4'h0;
                mode = MODE_FULL;
            end
            ACT_ROL:
            begin
                if (s1_reg.c != 6'd0)
                begin
                    z    = 64'((dbl << r) >> k) & m2;
                    cf   = z[0];
                    of   = ((z & s2m) != 64'd0) ^ z[0];
                    mode = MODE_ROT;
                end
            end
            ACT_ROR:
            begin
                if (s1_reg.c != 6'd0)
                begin
                    z    = 64'(dbl >> r) & m2;
                    cf   = (z & s2m) != 64'd0;
                    of   = ((z & s2m) != 64'd0) ^ ((z & s2h) != 64'd0);
                    mode = MODE_ROT;
                end
            end
            ACT_RCL:
            begin
                if (s1_reg.rc != 6'd0)
                begin
                    tmp  = {64'd0, x} >> (k - rc7);
                    cf   = tmp[0];
                    z    = ((x << rc7) | ({63'd0, cin} << (rc7 - 7'd1))
                           | (x >> (k + 7'd1 - rc7))) & m2;
                    of   = tmp[0] ^ ((z & s2m) != 64'd0);
                    mode = MODE_ROT;
                end
            end
            ACT_RCR:
            begin
                if (s1_reg.rc != 6'd0)
                begin
                    tmp  = {64'd0, x} >> (rc7 - 7'd1);
                    cf   = tmp[0];
                    z    = ((x >> rc7) | ({63'd0, cin} << (k - rc7))
                           | (x << (k + 7'd1 - rc7))) & m2;
                    of   = ((z & s2m) != 64'd0) ^ ((z & s2h) != 64'd0);
                    mode = MODE_ROT;
                end
            end
            ACT_SHL, ACT_SAL:
            begin
                if (s1_reg.c != 6'd0)
                begin
                    tmp  = {64'd0, x} >> (k - c7);
                    cf   = (c7 <= k) ? tmp[0] : 1'b0;
                    z    = (x << c7) & m2;
                    of   = ((z & s2m) != 64'd0) ^ cf;
                    mode = MODE_FULL;
                end
            end
            ACT_SHR:
            begin
                if (s1_reg.c != 6'd0)
                begin
                    tmp  = {64'd0, x} >> (c7 - 7'd1);
                    cf   = tmp[0];
                    z    = x >> c7;
                    of   = ((z & s2m) != 64'd0) ^ ((z & s2h) != 64'd0);
                    mode = MODE_FULL;
                end
            end
            ACT_SAR:
            begin
                if (s1_reg.c != 6'd0)
                begin
                    tmp  = {64'd0, 64'($signed(sx) >>> (c7 - 7'd1))};
                    cf   = tmp[0];
                    z    = 64'($signed(sx) >>> c7) & m2;
                    mode = MODE_FULL;
                end
            end
            ACT_SHRD:
            begin
                if (s1_reg.c != 6'd0)
                begin
                    vd   = ({64'd0, y} << k) | {64'd0, x};
                    tmp  = vd >> (c7 - 7'd1);
                    cf   = tmp[0];
                    z    = 64'(vd >> c7) & m2;
                    of   = (c7 == 7'd1) && ((z & s2m) != (x & s2m));
                    mode = MODE_FULL;
                end
            end
            ACT_SHLD:
            begin
                if (s1_reg.c != 6'd0)
                begin
                    vd   = ({64'd0, x} << k) | {64'd0, y};
                    tmp  = vd >> (k2 - {1'b0, c7});
                    cf   = ({1'b0, c7} <= k2) ? tmp[0] : 1'b0;
                    z    = 64'((vd << c7) >> k) & m2;
                    of   = (c7 == 7'd1) && ((z & s2m) != (x & s2m));
                    mode = MODE_FULL;
                end
            end
            default:
            begin
                z = x;
            end
        endcase

        s2_next.z     = z;
        s2_next.cf    = cf;
        s2_next.of    = of;
        s2_next.af    = af;
        s2_next.mode  = mode;
        s2_next.wcode = s1_reg.wcode;
        s2_next.fin   = s1_reg.fin;
        s2_next.pin   = s1_reg.pin;
    end

    // ---------------- stage 3: flag merge
    logic [63:0] result_next;
    logic [4:0]  flags_next;
    logic [7:0]  parity_next;
    logic        done_reg;
    logic [63:0] result_reg;
    logic [4:0]  flags_reg;
    logic [7:0]  parity_reg;
    logic        zf3, sf3;

    always_comb
    begin
        zf3         = s2_reg.z == 64'd0;
        sf3         = (s2_reg.z & width_msb(s2_reg.wcode)) != 64'd0;
        result_next = s2_reg.z;
        unique case (s2_reg.mode)
            MODE_FULL:
            begin
                flags_next  = {s2_reg.af, s2_reg.of, sf3, zf3, s2_reg.cf};
                parity_next = s2_reg.z[7:0];
            end
            MODE_ROT:
            begin
                flags_next  = {s2_reg.fin[FL_AF], s2_reg.of, s2_reg.fin[FL_SF],
                               s2_reg.fin[FL_ZF], s2_reg.cf};
                parity_next = s2_reg.pin;
            end
            default:
            begin
                flags_next  = s2_reg.fin;
                parity_next = s2_reg.pin;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start & ~busy;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        result_reg <= result_next;
        flags_reg  <= flags_next;
        parity_reg <= parity_next;
    end

    assign done            = done_reg;
    assign result          = result_reg;
    assign flags_out       = flags_reg;
    assign parity_byte_out = parity_reg;

endmodule

`default_nettype wire

>>> sv/x86asu_checker.sv
// ----------------------------------------------------------------------------
// x86asu_checker
// Port-level timing and flag checks for the x86 ALU/shift unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "x86_alu_shift_unit_with_flags_unit_macros.svh"

module x86asu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [4:0]  action,
    input wire logic [4:0]  flags_in,
    input wire logic [7:0]  parity_byte_in,
    input wire logic        done,
    input wire logic [4:0]  flags_out,
    input wire logic [7:0]  parity_byte_out
);
    import x86asu_pkg::*;

    `X86ASU_ASSERT(a_lat, (start && !busy) |-> ##3 done, "request lost in pipe")
    `X86ASU_ASSERT(a_nolat, !(start && !busy) |-> ##3 !done, "result without request")
    `X86ASU_ASSERT(a_not_keep, (start && !busy && action == ACT_NOT) |-> ##3 (flags_out == $past(flags_in, 3) && parity_byte_out == $past(parity_byte_in, 3)), "not changed flags")
    `X86ASU_NEVER(a_busy, busy, "busy raised")

endmodule

bind x86_alu_shift_unit_with_flags_unit x86asu_checker u_x86asu_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .flags_in        (flags_in),
    .parity_byte_in  (parity_byte_in),
    .done            (done),
    .flags_out       (flags_out),
    .parity_byte_out (parity_byte_out)
);

`default_nettype wire

>>> tb/tb_x86_alu_shift_unit_with_flags_unit.sv
// ----------------------------------------------------------------------------
// tb_x86_alu_shift_unit_with_flags_unit
// Self-checking bench for the x86 ALU/shift unit: a directed table of
// requests, then random requests, each checked against a typed expectation or an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_x86_alu_shift_unit_with_flags_unit;
    import x86asu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_RANDOM  = 1100;

    typedef struct packed {
        logic [63:0] res;
        logic [4:0]  flg;
        logic [7:0]  pbyte;
    } alu_out_t;

    typedef struct {
        logic [4:0]  act;
        logic [1:0]  wc;
        logic [63:0] a;
        logic [63:0] b;
        logic [7:0]  cnt;
        logic [4:0]  fl;
        logic [7:0]  pb;
        bit          typed;    // expected value written in the row
        alu_out_t    want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [4:0]  action;
    logic [1:0]  width_code;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [7:0]  shift_count;
    logic [4:0]  flags_in;
    logic [7:0]  parity_byte_in;
    logic        done;
    logic [63:0] result;
    logic [4:0]  flags_out;
    logic [7:0]  parity_byte_out;

    alu_out_t    pending_results[$];
    int          mismatch_count;
    longint      cycle_count;

    x86_alu_shift_unit_with_flags_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .width_code      (width_code),
        .operand_a       (operand_a),
        .operand_b       (operand_b),
        .shift_count     (shift_count),
        .flags_in        (flags_in),
        .parity_byte_in  (parity_byte_in),
        .done            (done),
        .result          (result),
        .flags_out       (flags_out),
        .parity_byte_out (parity_byte_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Flag word assembly for a full write: ZF/SF from the result, rest given.
    function automatic alu_out_t full_flags(input logic [63:0] z, input logic [63:0] msb,
                                            input logic cf, input logic of,
                                            input logic af);
        alu_out_t o;
        o.res = z;
        o.flg = '0;
        o.flg[FL_CF] = cf;
        o.flg[FL_ZF] = (z == 64'd0);
        o.flg[FL_SF] = ((z & msb) != 64'd0);
        o.flg[FL_OF] = of;
        o.flg[FL_AF] = af;
        o.pbyte = z[7:0];
        return o;
    endfunction

    // Expected result of one request.
    function automatic alu_out_t alu_predict(input logic [4:0] act, input logic [1:0] wc,
                                             input logic [63:0] a, input logic [63:0] b,
                                             input logic [7:0] cnt, input logic [4:0] fl,
                                             input logic [7:0] pb);
        alu_out_t    o;
        int unsigned k;
        int unsigned c;
        int unsigned r;
        logic [63:0] msb;
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] t;
        logic [63:0] sx;
        logic [127:0] v;
        logic        cin;
        logic        cf;
        logic        of;
        k   = 8 << wc;
        msb = 64'd1 << (k - 1);
        m   = msb | (msb - 64'd1);
        x   = a & m;
        y   = b & m;
        cin = fl[FL_CF];
        c   = (k == 64) ? cnt[5:0] : cnt[4:0];
        o.res = x;
        o.flg = fl;
        o.pbyte = pb;
        case (act)
            ACT_ADD:
            begin
                z = (x + y) & m;
                o = full_flags(z, msb, z < y, ((z ^ x) & (z ^ y) & msb) != 0,
                               z[3:0] < y[3:0]);
            end
            ACT_OR:  o = full_flags(x | y, msb, 1'b0, 1'b0, 1'b0);
            ACT_AND: o = full_flags(x & y, msb, 1'b0, 1'b0, 1'b0);
            ACT_XOR: o = full_flags(x ^ y, msb, 1'b0, 1'b0, 1'b0);
            ACT_ADC:
            begin
                t = (x + cin) & m;
                z = (t + y) & m;
                o = full_flags(z, msb, (t < x) | (z < y), ((z ^ x) & (z ^ y) & msb) != 0,
                               (t[3:0] < x[3:0]) | (z[3:0] < y[3:0]));
            end
            ACT_SBB:
            begin
                t = (x - cin) & m;
                z = (t - y) & m;
                o = full_flags(z, msb, (x < t) | (t < z), ((z ^ x) & (x ^ y) & msb) != 0,
                               (x[3:0] < t[3:0]) | (t[3:0] < z[3:0]));
            end
            ACT_SUB, ACT_CMP:
            begin
                z = (x - y) & m;
                o = full_flags(z, msb, x < z, ((x ^ y) & (z ^ x) & msb) != 0,
                               x[3:0] < z[3:0]);
            end
            ACT_NOT: o.res = ~x & m;
            ACT_NEG:
            begin
                z = (64'd0 - x) & m;
                o = full_flags(z, msb, x != 0, x == msb, x[3:0] != 0);
            end
            ACT_INC:
            begin
                z = (x + 64'd1) & m;
                o = full_flags(z, msb, cin, ((z ^ x) & z & msb) != 0, z[3:0] < x[3:0]);
            end
            ACT_DEC:
            begin
                z = (x - 64'd1) & m;
                o = full_flags(z, msb, cin, ((z ^ x) & x & msb) != 0, x[3:0] < z[3:0]);
            end
            ACT_ROL, ACT_ROR:
            begin
                if (c != 0)
                begin
                    r = c & (k - 1);
                    z = x;
                    if (r != 0)
                    begin
                        if (act == ACT_ROL)
                            z = ((x << r) | (x >> (k - r))) & m;
                        else
                            z = ((x >> r) | (x << (k - r))) & m;
                    end
                    o.res = z;
                    if (act == ACT_ROL)
                    begin
                        o.flg[FL_CF] = z[0];
                        o.flg[FL_OF] = z[k - 1] ^ z[0];
                    end
                    else
                    begin
                        o.flg[FL_CF] = z[k - 1];
                        o.flg[FL_OF] = z[k - 1] ^ z[k - 2];
                    end
                end
            end
            ACT_RCL, ACT_RCR:
            begin
                if (k == 8)
                    c = c % 9;
                else if (k == 16)
                    c = c % 17;
                if (c != 0)
                begin
                    // rotate through a (k+1)-bit value with CF on top
                    v = ({127'd0, cin} << k) | {64'd0, x};
                    if (act == ACT_RCL)
                        v = (v << c) | (v >> (k + 1 - c));
                    else
                        v = (v >> c) | (v << (k + 1 - c));
                    z  = v[63:0] & m;
                    cf = v[k];
                    o.res = z;
                    o.flg[FL_CF] = cf;
                    if (act == ACT_RCL)
                        o.flg[FL_OF] = cf ^ z[k - 1];
                    else
                        o.flg[FL_OF] = z[k - 1] ^ z[k - 2];
                end
            end
            ACT_SHL, ACT_SAL:
            begin
                if (c != 0)
                begin
                    cf = (c <= k) ? x[k - c] : 1'b0;
                    z  = (x << c) & m;
                    o  = full_flags(z, msb, cf, z[k - 1] ^ cf, 1'b0);
                end
            end
            ACT_SHR:
            begin
                if (c != 0)
                begin
                    z = x >> c;
                    o = full_flags(z, msb, x[c - 1], z[k - 1] ^ z[k - 2], 1'b0);
                end
            end
            ACT_SAR:
            begin
                if (c != 0)
                begin
                    sx = ((x & msb) != 0) ? (x | ~m) : x;
                    z  = 64'($signed(sx) >>> c) & m;
                    o  = full_flags(z, msb, sx[c - 1], 1'b0, 1'b0);
                end
            end
            ACT_SHLD, ACT_SHRD:
            begin
                if (c != 0)
                begin
                    if (act == ACT_SHRD)
                    begin
                        v  = (k == 64) ? {y, x} : {64'd0, (y << k) | x};
                        z  = 64'(v >> c) & m;
                        cf = v[c - 1];
                    end
                    else
                    begin
                        // destination above source, read back the top k bits
                        v  = {64'd0, x} << k | {64'd0, y};
                        z  = 64'(v >> (k - c)) & m;
                        if (k == 64)
                            cf = x[64 - c];
                        else
                            cf = (c <= 2 * k) ? v[2 * k - c] : 1'b0;
                        if (k != 64)
                            z = 64'((v << c) >> k) & m;
                    end
                    of = (c == 1) && ((z & msb) != (x & msb));
                    o  = full_flags(z, msb, cf, of, 1'b0);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Result check at each rising edge.
    always @(posedge clk)
    begin
        alu_out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", result, 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (result !== want.res)
                    report_mismatch("result", result, want.res);
                if (flags_out !== want.flg)
                    report_mismatch("flags_out", {59'd0, flags_out}, {59'd0, want.flg});
                if (parity_byte_out !== want.pbyte)
                    report_mismatch("parity_byte_out", {56'd0, parity_byte_out},
                                    {56'd0, want.pbyte});
            end
        end
    end

    // Log accepted requests; expectation comes from the row or the model.
    stim_row_t  cur_row;
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            if (cur_row.typed)
                pending_results.push_back(cur_row.want);
            else
                pending_results.push_back(alu_predict(action, width_code, operand_a,
                                                      operand_b, shift_count, flags_in,
                                                      parity_byte_in));
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Operand with bias toward edge values.
    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7));
            3:       return 64'h7fff_ffff_ffff_ffff >> (8 * $urandom_range(0, 7));
            4:       return 64'(($urandom_range(0, 31)));
            default: return rand64();
        endcase
    endfunction

    // Drive one request, waiting for acceptance; gap controls idling.
    task automatic send_request(input stim_row_t row, input bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_row        <= row;
        start          <= 1'b1;
        action         <= row.act;
        width_code     <= row.wc;
        operand_a      <= row.a;
        operand_b      <= row.b;
        shift_count    <= row.cnt;
        flags_in       <= row.fl;
        parity_byte_in <= row.pb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic stim_row_t mk(input logic [4:0] act, input logic [1:0] wc,
                                     input logic [63:0] a, input logic [63:0] b,
                                     input logic [7:0] cnt, input logic [4:0] fl,
                                     input logic [7:0] pb);
        stim_row_t r;
        r.act = act; r.wc = wc; r.a = a; r.b = b; r.cnt = cnt; r.fl = fl; r.pb = pb;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic stim_row_t mk_typed(input stim_row_t r, input logic [63:0] res,
                                           input logic [4:0] flg, input logic [7:0] pbyte);
        r.typed = 1'b1;
        r.want.res = res;
        r.want.flg = flg;
        r.want.pbyte = pbyte;
        return r;
    endfunction

    stim_row_t directed_rows[$];

    initial
    begin
        stim_row_t row;
        int        quiet_from;
        mismatch_count = 0;
        cycle_count    = 0;
        cur_row        = mk(ACT_ADD, 2'd0, 64'd0, 64'd0, 8'd0, 5'd0, 8'd0);
        rst_n          = 1'b0;
        start          = 1'b0;
        action         = '0;
        width_code     = '0;
        operand_a      = '0;
        operand_b      = '0;
        shift_count    = '0;
        flags_in       = '0;
        parity_byte_in = '0;

        // Directed table: extremes typed in, the rest predicted.
        // 8-bit 0xff + 1 wraps: CF, ZF, AF set.
        directed_rows.push_back(mk_typed(mk(ACT_ADD, 2'd0, 64'hff, 64'h1, 8'd0, 5'd0, 8'h5a),
                                         64'd0, 5'b10011, 8'h00));
        // 64-bit most negative minus one overflows.
        directed_rows.push_back(mk_typed(mk(ACT_SUB, WC_64, 64'h8000_0000_0000_0000, 64'd1,
                                            8'd0, 5'd0, 8'd0),
                                         64'h7fff_ffff_ffff_ffff, 5'b11000, 8'hff));
        // not passes flags and parity byte through
        directed_rows.push_back(mk_typed(mk(ACT_NOT, WC_64, '1, '1, 8'hff, 5'h1f, 8'ha5),
                                         64'd0, 5'h1f, 8'ha5));
        // count 32 masks to zero, which keeps everything but masks the operand
        directed_rows.push_back(mk_typed(mk(ACT_SHL, 2'd0, '1, 64'd0, 8'd32, 5'h0a, 8'h3c),
                                         64'hff, 5'h0a, 8'h3c));
        // unknown action code
        directed_rows.push_back(mk_typed(mk(5'd31, 2'd1, '1, '1, 8'h7, 5'h15, 8'h77),
                                         64'hffff, 5'h15, 8'h77));
        // every operation once, at a width that cycles through all four
        for (int op = 0; op <= 21; op++)
            directed_rows.push_back(mk(5'(op), 2'(op % 4), rand64(), rand64(),
                                       8'($urandom_range(1, 255)), 5'($urandom_range(0, 31)),
                                       8'($urandom_range(0, 255))));
        // rotate by a multiple of the width, rcl mod 9, rcr mod 17, shl past the width,
        // neg of most negative, shld/shrd counts beyond the width, sar by 63, inc to 0x80
        directed_rows.push_back(mk(ACT_ROL, 2'd0, 64'h81, 64'd0, 8'd16, 5'd0, 8'd0));
        directed_rows.push_back(mk(ACT_ROR, 2'd1, 64'h8001, 64'd0, 8'd16, 5'h1f, 8'd0));
        directed_rows.push_back(mk(ACT_RCL, 2'd0, 64'h80, 64'd0, 8'd9, 5'd1, 8'd0));
        directed_rows.push_back(mk(ACT_RCR, 2'd1, 64'h1, 64'd0, 8'd17, 5'd1, 8'd0));
        directed_rows.push_back(mk(ACT_SHL, 2'd0, 64'hff, 64'd0, 8'd9, 5'd0, 8'd0));
        directed_rows.push_back(mk(ACT_NEG, 2'd2, 64'h8000_0000, 64'd0, 8'd0, 5'd0, 8'd0));
        directed_rows.push_back(mk(ACT_SHLD, 2'd1, 64'h8001, 64'hc003, 8'd31, 5'd0, 8'd0));
        directed_rows.push_back(mk(ACT_SHRD, 2'd0, 64'h81, 64'hc3, 8'd17, 5'd0, 8'd0));
        directed_rows.push_back(mk(ACT_SAR, WC_64, 64'h8000_0000_0000_0000, 64'd0, 8'd63,
                                   5'd0, 8'd0));
        directed_rows.push_back(mk(ACT_INC, 2'd0, 64'h7f, 64'd0, 8'd0, 5'd1, 8'd0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i], 1'b1);

        // Random part; idling stops in the last stretch.
        quiet_from = NUM_RANDOM - 150;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            row = mk(5'($urandom_range(0, 23) > 21 ? $urandom_range(22, 31)
                                                   : $urandom_range(0, 21)),
                     2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                     8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 70)),
                     5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
            send_request(row, n < quiet_from && (n / 60) % 3 != 2);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
